// File: sv/pinhole_point_projection_unit_macros.svh
// Assertion macros for the pinhole point projection unit
`ifndef PINHOLE_POINT_PROJECTION_UNIT_MACROS_SVH
`define PINHOLE_POINT_PROJECTION_UNIT_MACROS_SVH
`ifndef SYNTH
// checked under reset too
`define PPP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("ppp assertion failed");
// checked outside reset only
`define PPP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ppp assertion failed");
`else
`define PPP_ASSERT_ALWAYS(lbl, clk, prop)
`define PPP_ASSERT(lbl, clk, rst_n, prop)
`endif
`endif

// File: sv/ppp_pkg.sv
// Types, constants and helpers of the pinhole point projection unit
`default_nettype none
package ppp_pkg;

    localparam int CAM_W    = 37;   // camera-frame coordinate, Q21.16
    localparam int NUM_W    = 62;   // focal length times coordinate
    localparam int MAG_W    = 60;   // magnitude of that product
    localparam int DIV_BITS = 33;   // quotient bits kept before saturation

    // configuration register indexes
    localparam logic [2:0] CFG_ROT_ROW0  = 3'd0;
    localparam logic [2:0] CFG_ROT_ROW1  = 3'd1;
    localparam logic [2:0] CFG_ROT_ROW2  = 3'd2;
    localparam logic [2:0] CFG_TRANS_XY  = 3'd3;
    localparam logic [2:0] CFG_TRANS_Z   = 3'd4;
    localparam logic [2:0] CFG_FOCAL     = 3'd5;
    localparam logic [2:0] CFG_PRINCIPAL = 3'd6;

    // near limit 0.1 in Q21.16
    localparam logic signed [CAM_W-1:0] NEAR_Q16 = 37'sd6554;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] pixel_u;
        logic signed [31:0] pixel_v;
        logic signed [31:0] depth;
        logic               visible;
    } t_out_word;

    // one axis of the restoring divider
    typedef struct packed {
        logic                neg;
        logic                ovf;
        logic [CAM_W-1:0]    rem;
        logic [DIV_BITS-1:0] low;
        logic [DIV_BITS-1:0] quo;
    } t_div_axis;

    typedef struct packed {
        t_div_axis          ax_u;
        t_div_axis          ax_v;
        logic [CAM_W-1:0]   z;
        logic signed [31:0] depth;
        logic               vis;
    } t_div_word;

    function automatic logic signed [31:0] sat_cam(input logic signed [CAM_W-1:0] x);
        logic signed [31:0] res;
        if (x > CAM_W'(SAT_MAX)) res = SAT_MAX;
        else if (x < CAM_W'(SAT_MIN)) res = SAT_MIN;
        else res = x[31:0];
        return res;
    endfunction

    function automatic logic signed [31:0] sat36(input logic signed [35:0] x);
        logic signed [31:0] res;
        if (x > 36'(SAT_MAX)) res = SAT_MAX;
        else if (x < 36'(SAT_MIN)) res = SAT_MIN;
        else res = x[31:0];
        return res;
    endfunction

    // one quotient bit: bring in the next dividend bit, subtract if it fits
    function automatic t_div_axis div_step(input t_div_axis a, input logic [CAM_W-1:0] z);
        t_div_axis          res;
        logic [CAM_W:0]     trial;
        trial = {a.rem, a.low[DIV_BITS-1]};
        res = a;
        res.low = {a.low[DIV_BITS-2:0], 1'b0};
        if (trial >= {1'b0, z}) begin
            res.rem = CAM_W'(trial - {1'b0, z});
            res.quo = {a.quo[DIV_BITS-2:0], 1'b1};
        end else begin
            res.rem = trial[CAM_W-1:0];
            res.quo = {a.quo[DIV_BITS-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: sv/pinhole_point_projection_unit.sv
// Pinhole perspective projection: one world point in, one pixel word out
//
// Input channel: i_in_valid / o_in_stall carry a word of three signed Q16.16
// world coordinates; it is taken at an edge with i_in_valid high and
// o_in_stall low. Output channel: o_out_valid / i_out_stall carry pixel_u,
// pixel_v (signed Q24.8, saturated), depth (signed Q16.16, saturated) and
// visible. Pixel coordinates are zero when depth is below 0.1.
// Configuration: write i_cfg_data to register i_cfg_idx when i_cfg_we is high,
// only while the pipeline holds no word.
// Stages: rotate, sum, translate, focal multiply, magnitude, range check,
// 33 restoring divider stages (one quotient bit each), final offset and
// saturation. One word a cycle is sustained unless the receiver stalls.
// When the receiver stalls, words pile up into empty stages behind the
// output register; o_in_stall rises only once every stage is full.
// Synchronous reset empties the pipeline and loads identity rotation,
// zero translation, fx = fy = 1.0 and zero principal point.
`default_nettype none
`include "pinhole_point_projection_unit_macros.svh"
module pinhole_point_projection_unit
    import ppp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_word    i_in_word,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_word        o_out_word
);

    localparam int NS       = 7 + DIV_BITS;  // register stages
    localparam int ST_DIV0  = 6;
    localparam int ST_FIN   = NS - 1;

    // configuration registers
    logic [47:0] r_rot [0:2];
    logic [63:0] r_trans_xy;
    logic [31:0] r_trans_z;
    logic [47:0] r_focal;
    logic [47:0] r_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0]   <= 48'h0000_0000_4000;
            r_rot[1]   <= 48'h0000_4000_0000;
            r_rot[2]   <= 48'h4000_0000_0000;
            r_trans_xy <= '0;
            r_trans_z  <= '0;
            r_focal    <= 48'h0001_0000_0100;
            r_pp       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROT_ROW0:  r_rot[0]   <= i_cfg_data[47:0];
                CFG_ROT_ROW1:  r_rot[1]   <= i_cfg_data[47:0];
                CFG_ROT_ROW2:  r_rot[2]   <= i_cfg_data[47:0];
                CFG_TRANS_XY:  r_trans_xy <= i_cfg_data;
                CFG_TRANS_Z:   r_trans_z  <= i_cfg_data[31:0];
                CFG_FOCAL:     r_focal    <= i_cfg_data[47:0];
                CFG_PRINCIPAL: r_pp       <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // stage enables: a stage loads when it is empty or its successor moves
    logic [NS-1:0] r_vld;
    logic [NS:0]   w_en;
    logic [NS-1:0] n_vld;

    always_comb begin
        w_en[NS] = ~i_out_stall;
        for (int i = NS - 1; i >= 0; i--) begin
            w_en[i] = ~r_vld[i] | w_en[i+1];
        end
        n_vld[0] = w_en[0] ? i_in_valid : r_vld[0];
        for (int i = 1; i < NS; i++) begin
            n_vld[i] = w_en[i] ? r_vld[i-1] : r_vld[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_stall  = ~w_en[0];
    assign o_out_valid = r_vld[ST_FIN];

    // stage 1: nine Q2.14 by Q16.16 products
    logic signed [31:0] w_pt [0:2];
    logic signed [47:0] n_s1_prod [0:2][0:2];
    logic signed [47:0] r_s1_prod [0:2][0:2];

    assign w_pt[0] = i_in_word.point_x;
    assign w_pt[1] = i_in_word.point_y;
    assign w_pt[2] = i_in_word.point_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_s1_prod[i][j] = $signed(r_rot[i][16*j +: 16]) * w_pt[j];
            end
        end
    end

    // stage 2: row sums, floor shift to Q20.16
    logic signed [49:0] n_s2_sum [0:2];
    logic signed [35:0] r_s2_row [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s2_sum[i] = 50'(r_s1_prod[i][0]) + 50'(r_s1_prod[i][1])
                        + 50'(r_s1_prod[i][2]);
        end
    end

    // stage 3: translation, near test, depth clamp
    logic signed [CAM_W-1:0] n_s3_cam [0:2];
    logic signed [CAM_W-1:0] r_s3_cam [0:2];
    logic signed [31:0]      r_s3_depth;
    logic                    r_s3_vis;

    always_comb begin
        n_s3_cam[0] = CAM_W'(r_s2_row[0]) + CAM_W'($signed(r_trans_xy[31:0]));
        n_s3_cam[1] = CAM_W'(r_s2_row[1]) + CAM_W'($signed(r_trans_xy[63:32]));
        n_s3_cam[2] = CAM_W'(r_s2_row[2]) + CAM_W'($signed(r_trans_z));
    end

    // stage 4: focal length times camera x and y
    logic signed [NUM_W-1:0] r_s4_num_u;
    logic signed [NUM_W-1:0] r_s4_num_v;
    logic [CAM_W-1:0]        r_s4_z;
    logic signed [31:0]      r_s4_depth;
    logic                    r_s4_vis;

    // stage 5: sign and magnitude
    logic             r_s5_neg_u;
    logic             r_s5_neg_v;
    logic [MAG_W-1:0] r_s5_mag_u;
    logic [MAG_W-1:0] r_s5_mag_v;
    logic [CAM_W-1:0] r_s5_z;
    logic signed [31:0] r_s5_depth;
    logic             r_s5_vis;

    logic signed [NUM_W-1:0] w_abs_u;
    logic signed [NUM_W-1:0] w_abs_v;
    assign w_abs_u = r_s4_num_u[NUM_W-1] ? -r_s4_num_u : r_s4_num_u;
    assign w_abs_v = r_s4_num_v[NUM_W-1] ? -r_s4_num_v : r_s4_num_v;

    // stage 6 and divider stages
    t_div_word r_div [0:DIV_BITS];
    t_div_word n_div0;

    always_comb begin
        n_div0.z     = r_s5_z;
        n_div0.depth = r_s5_depth;
        n_div0.vis   = r_s5_vis;
        // quotient beyond DIV_BITS bits saturates in any case
        n_div0.ax_u.neg = r_s5_neg_u;
        n_div0.ax_u.ovf = {10'b0, r_s5_mag_u} >= {r_s5_z, {DIV_BITS{1'b0}}};
        n_div0.ax_u.rem = CAM_W'(r_s5_mag_u[MAG_W-1:DIV_BITS]);
        n_div0.ax_u.low = r_s5_mag_u[DIV_BITS-1:0];
        n_div0.ax_u.quo = '0;
        n_div0.ax_v.neg = r_s5_neg_v;
        n_div0.ax_v.ovf = {10'b0, r_s5_mag_v} >= {r_s5_z, {DIV_BITS{1'b0}}};
        n_div0.ax_v.rem = CAM_W'(r_s5_mag_v[MAG_W-1:DIV_BITS]);
        n_div0.ax_v.low = r_s5_mag_v[DIV_BITS-1:0];
        n_div0.ax_v.quo = '0;
    end

    // arithmetic stages, payload without reset
    always_ff @(posedge i_clk) begin
        if (w_en[0]) r_s1_prod <= n_s1_prod;
        if (w_en[1]) begin
            for (int i = 0; i < 3; i++) r_s2_row[i] <= n_s2_sum[i][49:14];
        end
        if (w_en[2]) begin
            r_s3_cam   <= n_s3_cam;
            r_s3_depth <= sat_cam(n_s3_cam[2]);
            r_s3_vis   <= n_s3_cam[2] >= NEAR_Q16;
        end
        if (w_en[3]) begin
            r_s4_num_u <= NUM_W'($signed({1'b0, r_focal[23:0]}) * r_s3_cam[0]);
            r_s4_num_v <= NUM_W'($signed({1'b0, r_focal[47:24]}) * r_s3_cam[1]);
            r_s4_z     <= r_s3_cam[2];
            r_s4_depth <= r_s3_depth;
            r_s4_vis   <= r_s3_vis;
        end
        if (w_en[4]) begin
            r_s5_neg_u <= r_s4_num_u[NUM_W-1];
            r_s5_neg_v <= r_s4_num_v[NUM_W-1];
            r_s5_mag_u <= w_abs_u[MAG_W-1:0];
            r_s5_mag_v <= w_abs_v[MAG_W-1:0];
            r_s5_z     <= r_s4_z;
            r_s5_depth <= r_s4_depth;
            r_s5_vis   <= r_s4_vis;
        end
        if (w_en[5]) r_div[0] <= n_div0;
    end

    // restoring division, one quotient bit per stage for both axes
    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (w_en[ST_DIV0+k]) begin
                r_div[k+1].ax_u  <= div_step(r_div[k].ax_u, r_div[k].z);
                r_div[k+1].ax_v  <= div_step(r_div[k].ax_v, r_div[k].z);
                r_div[k+1].z     <= r_div[k].z;
                r_div[k+1].depth <= r_div[k].depth;
                r_div[k+1].vis   <= r_div[k].vis;
            end
        end
    end

    // final stage: sign, principal point, saturation, zero pixels if not visible
    logic signed [35:0] w_sq_u;
    logic signed [35:0] w_sq_v;
    logic signed [31:0] w_pix_u;
    logic signed [31:0] w_pix_v;
    t_out_word          n_out;
    t_out_word          r_out;

    always_comb begin
        w_sq_u = r_div[DIV_BITS].ax_u.neg ? -$signed({3'b0, r_div[DIV_BITS].ax_u.quo})
                                          :  $signed({3'b0, r_div[DIV_BITS].ax_u.quo});
        w_sq_v = r_div[DIV_BITS].ax_v.neg ? -$signed({3'b0, r_div[DIV_BITS].ax_v.quo})
                                          :  $signed({3'b0, r_div[DIV_BITS].ax_v.quo});
        if (r_div[DIV_BITS].ax_u.ovf)
            w_pix_u = r_div[DIV_BITS].ax_u.neg ? SAT_MIN : SAT_MAX;
        else
            w_pix_u = sat36(w_sq_u + $signed({12'b0, r_pp[23:0]}));
        if (r_div[DIV_BITS].ax_v.ovf)
            w_pix_v = r_div[DIV_BITS].ax_v.neg ? SAT_MIN : SAT_MAX;
        else
            w_pix_v = sat36(w_sq_v + $signed({12'b0, r_pp[47:24]}));
        n_out.visible = r_div[DIV_BITS].vis;
        n_out.depth   = r_div[DIV_BITS].depth;
        n_out.pixel_u = r_div[DIV_BITS].vis ? w_pix_u : '0;
        n_out.pixel_v = r_div[DIV_BITS].vis ? w_pix_v : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_FIN]) r_out <= n_out;
    end

    assign o_out_word = r_out;

    // checks
    `PPP_ASSERT(a_invisible_zero, i_clk, i_rst_n, o_out_valid && !o_out_word.visible |-> o_out_word.pixel_u == 0 && o_out_word.pixel_v == 0)
    `PPP_ASSERT(a_visible_depth, i_clk, i_rst_n, o_out_valid && o_out_word.visible |-> o_out_word.depth >= 32'sd6554)
    `PPP_ASSERT_ALWAYS(a_reset_empty, i_clk, !$past(i_rst_n) |-> r_vld == '0)
    `PPP_ASSERT(a_stall_full, i_clk, i_rst_n, o_in_stall |-> r_vld == {NS{1'b1}})

endmodule
`default_nettype wire
